// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and the control program of the radix-to-ASCII converter.
package itoa_pkg;

    // Digit and character types.
    typedef logic [5:0] t_digit;
    typedef logic [6:0] t_char;

    localparam t_digit RADIX_MIN  = 6'd2;
    localparam t_digit RADIX_MAX  = 6'd36;
    localparam t_digit RADIX_DEC  = 6'd10;
    localparam t_digit DIGIT_NINE = 6'd9;

    localparam t_char CHAR_ZERO  = 7'h30;
    localparam t_char CHAR_SEVEN = 7'h37;
    localparam t_char CHAR_MINUS = 7'h2D;

    // Program counter and step addresses.
    typedef logic [2:0] t_pc;

    localparam t_pc STEP_IDLE     = 3'd0;
    localparam t_pc STEP_DIV_INIT = 3'd1;
    localparam t_pc STEP_DIV_BIT  = 3'd2;
    localparam t_pc STEP_PUSH     = 3'd3;
    localparam t_pc STEP_SIGN_CHK = 3'd4;
    localparam t_pc STEP_SIGN     = 3'd5;
    localparam t_pc STEP_EMIT     = 3'd6;
    localparam t_pc STEP_DONE     = 3'd7;

    // What a step waits for before it executes.
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } t_wait;

    // Branch conditions; when false the counter simply advances.
    typedef enum logic [2:0] {
        BR_NEVER,
        BR_ALWAYS,
        BR_DIV_MORE,
        BR_MORE_DIGITS,
        BR_NO_SIGN,
        BR_NOT_LAST
    } t_branch;

    // One control word of the program.
    typedef struct packed {
        t_wait   wait_on;
        t_branch branch;
        t_pc     target;
        logic    accept;
        logic    div_init;
        logic    div_step;
        logic    push;
        logic    emit_sign;
        logic    emit_digit;
    } t_uop;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_more;
        logic more_digits;
        logic no_sign;
        logic not_last;
    } t_status;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic div_init;
        logic div_step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } t_ctrl;

    // The control program, one word per step.
    function automatic t_uop rom_word(input t_pc pc);
        t_uop w;
        w = '{wait_on: WAIT_NONE, branch: BR_NEVER, target: STEP_IDLE, default: 1'b0};
        case (pc)
            STEP_IDLE: begin
                w.wait_on = WAIT_IN;
                w.accept  = 1'b1;
            end
            STEP_DIV_INIT: begin
                w.div_init = 1'b1;
            end
            STEP_DIV_BIT: begin
                w.div_step = 1'b1;
                w.branch   = BR_DIV_MORE;
                w.target   = STEP_DIV_BIT;
            end
            STEP_PUSH: begin
                w.push   = 1'b1;
                w.branch = BR_MORE_DIGITS;
                w.target = STEP_DIV_INIT;
            end
            STEP_SIGN_CHK: begin
                w.branch = BR_NO_SIGN;
                w.target = STEP_EMIT;
            end
            STEP_SIGN: begin
                w.wait_on   = WAIT_OUT;
                w.emit_sign = 1'b1;
            end
            STEP_EMIT: begin
                w.wait_on    = WAIT_OUT;
                w.emit_digit = 1'b1;
                w.branch     = BR_NOT_LAST;
                w.target     = STEP_EMIT;
            end
            STEP_DONE: begin
                w.branch = BR_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: begin
                w.branch = BR_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // ASCII code of one digit value.
    function automatic t_char digit_char(input t_digit d);
        if (d > DIGIT_NINE) begin
            return CHAR_SEVEN + {1'b0, d};
        end
        return CHAR_ZERO + {1'b0, d};
    endfunction

endpackage

// ===== rtl/itoa_seq.sv =====
// Microcode sequencer: step counter, program table and branch logic.
module itoa_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  itoa_pkg::t_status i_status,
    output itoa_pkg::t_ctrl   o_ctrl
);
    import itoa_pkg::*;

    t_pc  r_pc;
    t_pc  n_pc;
    t_uop uop;
    logic go;
    logic taken;

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Decode the current word, resolve the wait and the branch.
    always_comb begin
        uop = rom_word(r_pc);
        case (uop.wait_on)
            WAIT_NONE: go = 1'b1;
            WAIT_IN:   go = i_status.in_valid;
            WAIT_OUT:  go = i_status.out_free;
            default:   go = 1'b0;
        endcase
        case (uop.branch)
            BR_NEVER:       taken = 1'b0;
            BR_ALWAYS:      taken = 1'b1;
            BR_DIV_MORE:    taken = i_status.div_more;
            BR_MORE_DIGITS: taken = i_status.more_digits;
            BR_NO_SIGN:     taken = i_status.no_sign;
            BR_NOT_LAST:    taken = i_status.not_last;
            default:        taken = 1'b0;
        endcase
        if (!go) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = uop.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
        o_ctrl.in_ready   = (uop.wait_on == WAIT_IN);
        o_ctrl.accept     = uop.accept & go;
        o_ctrl.div_init   = uop.div_init & go;
        o_ctrl.div_step   = uop.div_step & go;
        o_ctrl.push       = uop.push & go;
        o_ctrl.emit_sign  = uop.emit_sign & go;
        o_ctrl.emit_digit = uop.emit_digit & go;
    end

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// Top level: signed integer to ASCII digits in a radix from 2 to 36.
//
//   Channel | Direction | Handshake          | Payload
//   input   | in        | i_valid / o_ready  | i_value, i_radix
//   output  | out       | o_valid / i_ready  | o_char_code, o_last_char
//
// Digits are produced by the bit-serial restoring divider, which yields one
// quotient bit per cycle.
// Digits are stacked least significant first and popped most significant first.
// Reset returns the sequencer to its idle step and empties the output register.
// A stalled output holds the sequencer in its sign or emit step; a new item is taken
// only once the previous string has been handed to the output register.
module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  itoa_pkg::t_digit              i_radix,
    output logic                          o_valid,
    input  logic                          i_ready,
    output itoa_pkg::t_char               o_char_code,
    output logic                          o_last_char
);
    import itoa_pkg::*;

    localparam int DIGIT_W = $bits(t_digit);
    localparam int STACK_W = VALUE_WIDTH * DIGIT_W;
    localparam int BIT_W   = $clog2(VALUE_WIDTH);
    localparam int NDIG_W  = $clog2(VALUE_WIDTH + 1);
    localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(VALUE_WIDTH - 1);
    localparam logic [NDIG_W-1:0] DIG_LAST = NDIG_W'(VALUE_WIDTH - 1);
    localparam logic [NDIG_W-1:0] DIG_ONE  = NDIG_W'(1);

    t_ctrl   ctrl;
    t_status status;

    logic [VALUE_WIDTH-1:0] r_mag;
    t_digit                 r_radix;
    t_digit                 r_rem;
    logic [BIT_W-1:0]       r_bitcnt;
    logic [NDIG_W-1:0]      r_ndig;
    logic [STACK_W-1:0]     r_stack;
    logic                   r_minus;
    logic                   r_out_valid;
    t_char                  r_out_char;
    logic                   r_out_last;

    t_digit                 radix_sat;
    logic                   put_minus;
    logic [DIGIT_W:0]       rem_sh;
    logic                   rem_ge;
    logic                   out_free;

    itoa_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // Input decode and one step of the restoring divider.
    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_sat = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_sat = RADIX_MAX;
        end else begin
            radix_sat = i_radix;
        end
        put_minus = i_value[VALUE_WIDTH-1] && (radix_sat == RADIX_DEC);
        rem_sh    = {r_rem, r_mag[VALUE_WIDTH-1]};
        rem_ge    = (rem_sh >= {1'b0, r_radix});
        out_free  = !r_out_valid || i_ready;
    end

    // Status for the sequencer.
    always_comb begin
        status.in_valid    = i_valid;
        status.out_free    = out_free;
        status.div_more    = (r_bitcnt != BIT_LAST);
        status.more_digits = (r_mag != '0) && (r_ndig < DIG_LAST);
        status.no_sign     = !r_minus;
        status.not_last    = (r_ndig != DIG_ONE);
    end

    // Magnitude, divider and digit stack.
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_radix <= radix_sat;
            r_minus <= put_minus;
            r_mag   <= put_minus ? (~i_value + 1'b1) : i_value;
        end
        if (ctrl.div_init) begin
            r_rem    <= '0;
            r_bitcnt <= '0;
        end
        if (ctrl.div_step) begin
            r_rem    <= rem_ge ? DIGIT_W'(rem_sh - {1'b0, r_radix}) : DIGIT_W'(rem_sh);
            r_mag    <= {r_mag[VALUE_WIDTH-2:0], rem_ge};
            r_bitcnt <= r_bitcnt + 1'b1;
        end
        if (ctrl.push) begin
            r_stack <= {r_stack[STACK_W-DIGIT_W-1:0], r_rem};
        end else if (ctrl.emit_digit) begin
            r_stack <= {DIGIT_W'(0), r_stack[STACK_W-1:DIGIT_W]};
        end
    end

    // Digit count, cleared at the start of each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig <= '0;
        end else if (ctrl.accept) begin
            r_ndig <= '0;
        end else if (ctrl.push) begin
            r_ndig <= r_ndig + 1'b1;
        end else if (ctrl.emit_digit) begin
            r_ndig <= r_ndig - 1'b1;
        end
    end

    // Output register: a character waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit_sign || ctrl.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (ctrl.emit_digit) begin
            r_out_char <= digit_char(r_stack[DIGIT_W-1:0]);
            r_out_last <= (r_ndig == DIG_ONE);
        end
    end

    assign o_ready     = ctrl.in_ready;
    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last_char = r_out_last;

    // A digit is only popped from a non-empty stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit_digit |-> (r_ndig != '0))
        else $error("digit popped from an empty stack");

    // The stack never takes more digits than it holds.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.push |-> (r_ndig < NDIG_W'(VALUE_WIDTH)))
        else $error("digit stack overflow");

    // The partial remainder stays below the radix after every divider step.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.div_step |=> (r_rem < r_radix))
        else $error("divider remainder out of range");

    // A character is loaded only when the output register is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.emit_sign || ctrl.emit_digit) |-> (!r_out_valid || i_ready))
        else $error("output register overwritten before its transfer");

endmodule

// ===== tb/integer_to_radix_ascii_tb.sv =====
// Self-checking testbench for the integer to radix ASCII converter.
module integer_to_radix_ascii_tb;

    import itoa_pkg::*;

    localparam int W          = 32;
    localparam int IDLE_LIMIT = 10000;
    localparam int DRAIN      = 200;
    localparam int QUIET_TAIL = 30;
    localparam int N_RANDOM   = 310;

    // One pending conversion; hold makes the driver wait for an empty scoreboard.
    typedef struct {
        logic signed [W-1:0] value;
        t_digit              radix;
        bit                  hold;
    } conv_item_t;

    // One expected output character.
    typedef struct {
        t_char code;
        logic  is_last;
    } char_item_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic signed [W-1:0] i_value;
    t_digit              i_radix;
    logic                o_valid;
    logic                i_ready;
    t_char               o_char_code;
    logic                o_last_char;

    conv_item_t conv_q[$];
    char_item_t char_q[$];
    char_item_t head_char;

    logic in_taken;
    int   src_gap;
    int   sink_gap;
    int   idle_cycles;
    int   n_sent;
    int   n_chars;
    int   n_err;

    integer_to_radix_ascii #(
        .VALUE_WIDTH(W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_radix    (i_radix),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queue up the characters that one conversion must produce.
    function automatic void predict_string(input logic signed [W-1:0] value,
                                           input t_digit radix);
        longint unsigned mag;
        longint unsigned base;
        logic [W-1:0]    uval;
        t_digit          digs[W];
        t_char           code;
        bit              neg;
        int              n;
        int              k;
        if (radix < RADIX_MIN) begin
            base = 64'(RADIX_MIN);
        end else if (radix > RADIX_MAX) begin
            base = 64'(RADIX_MAX);
        end else begin
            base = 64'(radix);
        end
        // Only decimal treats the value as signed.
        neg  = value[W-1] && (base == 64'(RADIX_DEC));
        uval = value;
        if (neg) begin
            uval = ~uval + 1'b1;
        end
        mag = 64'(uval);
        n   = 0;
        do begin
            digs[n] = t_digit'(mag % base);
            mag     = mag / base;
            n++;
        end while (mag != 0 && n < W);
        if (neg) begin
            char_q.push_back('{code: CHAR_MINUS, is_last: 1'b0});
        end
        for (k = n - 1; k >= 0; k--) begin
            if (digs[k] > DIGIT_NINE) begin
                code = CHAR_SEVEN + {1'b0, digs[k]};
            end else begin
                code = CHAR_ZERO + {1'b0, digs[k]};
            end
            char_q.push_back('{code: code, is_last: (k == 0)});
        end
    endfunction

    task automatic add_item(input logic signed [W-1:0] value, input t_digit radix,
                            input bit hold);
        conv_q.push_back('{value: value, radix: radix, hold: hold});
    endtask

    // Random value drawn from a mix of widths and corner values.
    function automatic logic signed [W-1:0] pick_value();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = $urandom;
            2:       v = $signed($urandom_range(0, 200)) - 100;
            3:       v = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            4: begin
                case ($urandom_range(0, 4))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = -1;
                    3:       v = {1'b1, {(W-1){1'b0}}};
                    default: v = {1'b0, {(W-1){1'b1}}};
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // Random radix: mostly legal, some common bases, some out of range.
    function automatic t_digit pick_radix();
        t_digit r;
        case ($urandom_range(0, 7))
            6: begin
                case ($urandom_range(0, 3))
                    0:       r = 6'd2;
                    1:       r = 6'd8;
                    2:       r = RADIX_DEC;
                    default: r = 6'd16;
                endcase
            end
            7:       r = t_digit'($urandom_range(0, 63));
            default: r = t_digit'($urandom_range(RADIX_MIN, RADIX_MAX));
        endcase
        return r;
    endfunction

    // Driver: present the next conversion once the previous transfer is done.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (conv_q.size() > 0 && (!conv_q[0].hold || char_q.size() == 0))
                begin
                    if (conv_q.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                        src_gap <= $urandom_range(0, 5);
                        i_valid <= 1'b0;
                    end else begin
                        i_value <= conv_q[0].value;
                        i_radix <= conv_q[0].radix;
                        i_valid <= 1'b1;
                        void'(conv_q.pop_front());
                        n_sent++;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready with random stall bursts, none near the end.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_ready  <= 1'b0;
        end else if (conv_q.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            sink_gap <= $urandom_range(0, 5);
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: check each output transfer, then predict from each input transfer.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected character: char_code %h last_char %b",
                           o_char_code, o_last_char);
                    n_err++;
                end else begin
                    head_char = char_q.pop_front();
                    n_chars++;
                    if (o_char_code !== head_char.code) begin
                        $error("char_code: expected %h, actual %h", head_char.code,
                               o_char_code);
                        n_err++;
                    end
                    if (o_last_char !== head_char.is_last) begin
                        $error("last_char: expected %b, actual %b", head_char.is_last,
                               o_last_char);
                        n_err++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                predict_string(i_value, i_radix);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_value     = '0;
        i_radix     = '0;
        in_taken    = 1'b0;
        src_gap     = 0;
        sink_gap    = 0;
        idle_cycles = 0;
        n_sent      = 0;
        n_chars     = 0;
        n_err       = 0;

        // Directed: zero, extremes, sign handling and radix saturation.
        add_item(0, RADIX_DEC, 1'b0);
        add_item(0, 6'd2, 1'b0);
        add_item(0, RADIX_MAX, 1'b0);
        add_item(1, RADIX_DEC, 1'b0);
        add_item(9, RADIX_DEC, 1'b0);
        add_item(-1, RADIX_DEC, 1'b0);
        add_item(-1, 6'd2, 1'b0);
        add_item(-1, 6'd16, 1'b0);
        add_item({1'b1, {(W-1){1'b0}}}, RADIX_DEC, 1'b0);
        add_item({1'b1, {(W-1){1'b0}}}, 6'd2, 1'b1);
        add_item({1'b1, {(W-1){1'b0}}}, RADIX_MAX, 1'b0);
        add_item({1'b0, {(W-1){1'b1}}}, RADIX_DEC, 1'b0);
        add_item({1'b0, {(W-1){1'b1}}}, 6'd2, 1'b0);
        add_item({1'b0, {(W-1){1'b1}}}, RADIX_MAX, 1'b0);
        add_item(35, RADIX_MAX, 1'b0);
        add_item(10, 6'd11, 1'b0);
        add_item(-12345, RADIX_DEC, 1'b0);
        add_item(-12345, 6'd7, 1'b0);
        add_item(5, 6'd0, 1'b0);
        add_item(-6, 6'd1, 1'b0);
        add_item(1295, 6'd37, 1'b0);
        add_item(-1295, 6'd63, 1'b0);
        add_item(32'hDEADBEEF, 6'd16, 1'b0);

        // Random conversions, with an occasional wait for the scoreboard to drain.
        for (int i = 0; i < N_RANDOM; i++) begin
            add_item(pick_value(), pick_radix(), (i % 60) == 59);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (conv_q.size() != 0 || i_valid || char_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        $display("Converted %0d integers into %0d checked characters, radix codes 0 to 63.",
                 n_sent, n_chars);
        $display("Covered decimal signs, the most negative value and saturated radices.");
        if (n_err == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
